[hdl/bmac_pkg.sv]
// shared types and constants of the blend-mode alpha compositor
// no dependencies; used by every module of the block
`default_nettype none
package bmac_pkg;

	localparam int CHAN_W     = 8;   // one color channel byte
	localparam int OPA_W      = 9;   // q8 opacity, 256 is opaque
	localparam int WGT_W      = 17;  // background weight (256 - a2) * a1
	localparam int DEN_W      = 17;  // a2 * 256 + weight, up to 65536
	localparam int NUM_W      = 24;  // weighted sum, below 256 * den
	localparam int DIV_STAGES = 4;   // two quotient bits per stage
	localparam int PIPE_DEPTH = 8;   // register stages ahead of the output buffer
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [OPA_W-1:0] Q8_ONE = 9'd256;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FG_OPACITY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BG_OPACITY = 2'd2;

	typedef enum logic [2:0] {
		MODE_NORMAL   = 3'd0,
		MODE_MULTIPLY = 3'd1,
		MODE_SUBTRACT = 3'd2,
		MODE_MAX      = 3'd3,
		MODE_MIN      = 3'd4
	} bmac_mode_t;

	// compositing weights of one pixel
	typedef struct packed {
		logic [OPA_W-1:0] a2;
		logic [WGT_W-1:0] w1;
	} bmac_wgt_t;

	// one finished pixel
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              last;
	} bmac_pix_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [1:0]       q2;
	} bmac_div_t;

	// two restoring division steps, quotient bits hi and hi-1
	function automatic bmac_div_t div_step2(input logic [NUM_W-1:0] rem,
	                                        input logic [DEN_W-1:0] den,
	                                        input logic [2:0] hi);
		logic [NUM_W:0] r;
		logic [NUM_W:0] d;
		logic [1:0]     q;
		bmac_div_t      res;
		r = {1'b0, rem};
		q = 2'b00;
		for (int i = 0; i < 2; i++) begin
			d = {{(NUM_W + 1 - DEN_W){1'b0}}, den} << (hi - 3'(i));
			if (r >= d) begin
				r = r - d;
				q[1 - i] = 1'b1;
			end
		end
		res.rem = r[NUM_W-1:0];
		res.q2  = q;
		return res;
	endfunction

endpackage
`default_nettype wire

[hdl/blend_mode_alpha_compositor_unit.sv]
// top level of the blend-mode alpha compositor: config registers, control pipeline
// depends on bmac_pkg, bmac_chan, bmac_div, bmac_obuf
// throughput: one pixel per cycle while in_stall is low; 8 register stages (blend,
//   weights, products, sum, four divider stages of two quotient bits) all advance
//   on one shared enable
// in_stall rises only once the output slot and its skid slot both hold results
// reset: blend_mode normal, both opacities 256, pipeline and output buffer empty
`default_nettype none
module blend_mode_alpha_compositor_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// pixel input transaction
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [bmac_pkg::CHAN_W-1:0]      fg_red,
	input  wire logic [bmac_pkg::CHAN_W-1:0]      fg_green,
	input  wire logic [bmac_pkg::CHAN_W-1:0]      fg_blue,
	input  wire logic [bmac_pkg::CHAN_W-1:0]      bg_red,
	input  wire logic [bmac_pkg::CHAN_W-1:0]      bg_green,
	input  wire logic [bmac_pkg::CHAN_W-1:0]      bg_blue,
	input  wire logic                             fg_present,
	input  wire logic                             last_pixel,
	// pixel output transaction
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [bmac_pkg::CHAN_W-1:0]           out_red,
	output logic [bmac_pkg::CHAN_W-1:0]           out_green,
	output logic [bmac_pkg::CHAN_W-1:0]           out_blue,
	output logic                                  out_last,
	// configuration write port
	input  wire logic                             cfg_we,
	input  wire logic [bmac_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [bmac_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// configuration registers
	logic [2:0]                 blend_mode_q;
	logic [bmac_pkg::OPA_W-1:0] fg_opacity_q;
	logic [bmac_pkg::OPA_W-1:0] bg_opacity_q;

	// shared pipeline enable, held off only while the output buffer is full
	logic en;
	logic full;

	// valid and last travel alongside the data, one bit per stage
	logic [bmac_pkg::PIPE_DEPTH-1:0] vld_s;
	logic [bmac_pkg::PIPE_DEPTH-1:0] last_s;

	// stage 1: saturated opacities and background weight
	logic [bmac_pkg::OPA_W-1:0] a2_sat;
	logic [bmac_pkg::OPA_W-1:0] a1_sat;
	logic [bmac_pkg::WGT_W-1:0] w1_full;
	logic [2:0]                 mode_s1;
	logic [bmac_pkg::OPA_W-1:0] a2_s1;
	logic [bmac_pkg::WGT_W-1:0] w1_s1;
	logic                       present_s1;

	// stage 2: effective weights and denominator
	bmac_pkg::bmac_wgt_t        wgt_nxt;
	logic [bmac_pkg::DEN_W-1:0] den_nxt;
	bmac_pkg::bmac_wgt_t        wgt_s2;
	logic [bmac_pkg::DEN_W-1:0] den_s2;
	logic [bmac_pkg::DEN_W-1:0] den_s3;
	logic [bmac_pkg::DEN_W-1:0] den_s4;

	logic [bmac_pkg::NUM_W-1:0]  num_red_s4;
	logic [bmac_pkg::NUM_W-1:0]  num_green_s4;
	logic [bmac_pkg::NUM_W-1:0]  num_blue_s4;
	logic [bmac_pkg::CHAN_W-1:0] quo_red;
	logic [bmac_pkg::CHAN_W-1:0] quo_green;
	logic [bmac_pkg::CHAN_W-1:0] quo_blue;

	bmac_pkg::bmac_pix_t pix_done;
	bmac_pkg::bmac_pix_t pix_q;
	logic                push;

	// register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= bmac_pkg::MODE_NORMAL;
			fg_opacity_q <= bmac_pkg::Q8_ONE;
			bg_opacity_q <= bmac_pkg::Q8_ONE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bmac_pkg::REG_BLEND_MODE: blend_mode_q <= cfg_data[2:0];
				bmac_pkg::REG_FG_OPACITY: fg_opacity_q <= cfg_data;
				bmac_pkg::REG_BG_OPACITY: bg_opacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = ~full;
	assign in_stall = full;

	// control pipeline: valid bits cleared by reset, last is payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[bmac_pkg::PIPE_DEPTH-2:0], in_valid};
		end
	end

	// opacity above 256 acts as fully opaque
	assign a2_sat  = (fg_opacity_q > bmac_pkg::Q8_ONE) ? bmac_pkg::Q8_ONE : fg_opacity_q;
	assign a1_sat  = (bg_opacity_q > bmac_pkg::Q8_ONE) ? bmac_pkg::Q8_ONE : bg_opacity_q;
	assign w1_full = (bmac_pkg::WGT_W'(bmac_pkg::Q8_ONE) - bmac_pkg::WGT_W'(a2_sat))
	               * bmac_pkg::WGT_W'(a1_sat);

	// outside the foreground: weights 0 and 1 pass the background byte through;
	// both opacities zero: zero numerator over a unit denominator gives 0
	always_comb begin
		priority if (!present_s1) begin
			wgt_nxt.a2 = '0;
			wgt_nxt.w1 = bmac_pkg::WGT_W'(1);
			den_nxt    = bmac_pkg::DEN_W'(1);
		end else if (a2_s1 == '0 && w1_s1 == '0) begin
			wgt_nxt.a2 = '0;
			wgt_nxt.w1 = '0;
			den_nxt    = bmac_pkg::DEN_W'(1);
		end else begin
			wgt_nxt.a2 = a2_s1;
			wgt_nxt.w1 = w1_s1;
			den_nxt    = {a2_s1, 8'd0} + w1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s     <= {last_s[bmac_pkg::PIPE_DEPTH-2:0], last_pixel};
			mode_s1    <= blend_mode_q;
			a2_s1      <= a2_sat;
			w1_s1      <= w1_full;
			present_s1 <= fg_present;
			wgt_s2     <= wgt_nxt;
			den_s2     <= den_nxt;
			den_s3     <= den_s2;
			den_s4     <= den_s3;
		end
	end

	// per-channel blend and weighted sum, stages 1 to 4
	bmac_chan u_chan_red (
		.clk     (clk),
		.en      (en),
		.fg      (fg_red),
		.bg      (bg_red),
		.mode_s1 (mode_s1),
		.wgt_s2  (wgt_s2),
		.num_s4  (num_red_s4)
	);

	bmac_chan u_chan_green (
		.clk     (clk),
		.en      (en),
		.fg      (fg_green),
		.bg      (bg_green),
		.mode_s1 (mode_s1),
		.wgt_s2  (wgt_s2),
		.num_s4  (num_green_s4)
	);

	bmac_chan u_chan_blue (
		.clk     (clk),
		.en      (en),
		.fg      (fg_blue),
		.bg      (bg_blue),
		.mode_s1 (mode_s1),
		.wgt_s2  (wgt_s2),
		.num_s4  (num_blue_s4)
	);

	// per-channel division by the shared denominator, stages 5 to 8
	bmac_div u_div_red (
		.clk    (clk),
		.en     (en),
		.num_s4 (num_red_s4),
		.den_s4 (den_s4),
		.quo    (quo_red)
	);

	bmac_div u_div_green (
		.clk    (clk),
		.en     (en),
		.num_s4 (num_green_s4),
		.den_s4 (den_s4),
		.quo    (quo_green)
	);

	bmac_div u_div_blue (
		.clk    (clk),
		.en     (en),
		.num_s4 (num_blue_s4),
		.den_s4 (den_s4),
		.quo    (quo_blue)
	);

	assign pix_done.red   = quo_red;
	assign pix_done.green = quo_green;
	assign pix_done.blue  = quo_blue;
	assign pix_done.last  = last_s[bmac_pkg::PIPE_DEPTH-1];
	assign push           = en & vld_s[bmac_pkg::PIPE_DEPTH-1];

	// output register plus skid slot
	bmac_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pix_in    (pix_done),
		.out_stall (out_stall),
		.pix_q     (pix_q),
		.out_valid (out_valid),
		.full      (full)
	);

	assign out_red   = pix_q.red;
	assign out_green = pix_q.green;
	assign out_blue  = pix_q.blue;
	assign out_last  = pix_q.last;

	a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s[0])
		else $error("accepted transaction did not enter the first stage");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] |-> (den_s2 != '0))
		else $error("zero denominator reached the divider");

	a_out_held_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pix_q)))
		else $error("stalled output transaction changed or dropped");

endmodule
`default_nettype wire

[hdl/bmac_chan.sv]
// per-channel front end: blend by mode and weighted sum, stages s1 to s4
// depends on bmac_pkg
`default_nettype none
module bmac_chan (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [bmac_pkg::CHAN_W-1:0]    fg,
	input  wire logic [bmac_pkg::CHAN_W-1:0]    bg,
	input  wire logic [2:0]                     mode_s1,
	input  wire bmac_pkg::bmac_wgt_t            wgt_s2,
	output logic [bmac_pkg::NUM_W-1:0]          num_s4
);

	logic [bmac_pkg::CHAN_W-1:0]   fg_s1;
	logic [bmac_pkg::CHAN_W-1:0]   bg_s1;
	logic [2*bmac_pkg::CHAN_W-1:0] prod_s1;
	logic [bmac_pkg::CHAN_W-1:0]   b_s2;
	logic [bmac_pkg::CHAN_W-1:0]   bg_s2;
	logic [bmac_pkg::CHAN_W-1:0]   b_blend;
	logic [bmac_pkg::OPA_W+bmac_pkg::CHAN_W-1:0] pa_s3;
	logic [bmac_pkg::NUM_W:0]      pb_s3;
	logic [2*bmac_pkg::CHAN_W:0]   div255;
	logic [bmac_pkg::NUM_W:0]      sum;

	// floor(p / 255) in bits 15:8, for p up to 255 * 255
	assign div255 = {1'b0, prod_s1} + 17'd1 + {9'd0, prod_s1[15:8]};

	always_comb begin
		unique case (mode_s1)
			bmac_pkg::MODE_MULTIPLY: b_blend = div255[15:8];
			bmac_pkg::MODE_SUBTRACT: b_blend = (fg_s1 > bg_s1) ? (fg_s1 - bg_s1) : '0;
			bmac_pkg::MODE_MAX:      b_blend = (fg_s1 > bg_s1) ? fg_s1 : bg_s1;
			bmac_pkg::MODE_MIN:      b_blend = (fg_s1 < bg_s1) ? fg_s1 : bg_s1;
			default:                 b_blend = fg_s1;
		endcase
	end

	assign sum = {pa_s3, 8'd0} + pb_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			fg_s1   <= fg;
			bg_s1   <= bg;
			prod_s1 <= (2*bmac_pkg::CHAN_W)'(fg) * (2*bmac_pkg::CHAN_W)'(bg);
			b_s2    <= b_blend;
			bg_s2   <= bg_s1;
			pa_s3   <= (bmac_pkg::OPA_W+bmac_pkg::CHAN_W)'(wgt_s2.a2)
			         * (bmac_pkg::OPA_W+bmac_pkg::CHAN_W)'(b_s2);
			pb_s3   <= (bmac_pkg::NUM_W + 1)'(wgt_s2.w1)
			         * (bmac_pkg::NUM_W + 1)'(bg_s2);
			num_s4  <= sum[bmac_pkg::NUM_W-1:0];
		end
	end

endmodule
`default_nettype wire

[hdl/bmac_div.sv]
// pipelined restoring divider, 8-bit quotient over four stages s5 to s8
// depends on bmac_pkg
`default_nettype none
module bmac_div (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [bmac_pkg::NUM_W-1:0]  num_s4,
	input  wire logic [bmac_pkg::DEN_W-1:0]  den_s4,
	output logic [bmac_pkg::CHAN_W-1:0]      quo
);

	logic [bmac_pkg::NUM_W-1:0]  rem_s [bmac_pkg::DIV_STAGES];
	logic [bmac_pkg::DEN_W-1:0]  den_s [bmac_pkg::DIV_STAGES];
	logic [bmac_pkg::CHAN_W-1:0] q_s   [bmac_pkg::DIV_STAGES];
	bmac_pkg::bmac_div_t         step  [bmac_pkg::DIV_STAGES];

	always_comb begin
		step[0] = bmac_pkg::div_step2(num_s4, den_s4, 3'(bmac_pkg::CHAN_W - 1));
		for (int k = 1; k < bmac_pkg::DIV_STAGES; k++) begin
			step[k] = bmac_pkg::div_step2(rem_s[k-1], den_s[k-1],
			                              3'(bmac_pkg::CHAN_W - 1 - 2 * k));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= step[0].rem;
			den_s[0] <= den_s4;
			q_s[0]   <= {6'd0, step[0].q2};
			for (int k = 1; k < bmac_pkg::DIV_STAGES; k++) begin
				rem_s[k] <= step[k].rem;
				den_s[k] <= den_s[k-1];
				q_s[k]   <= {q_s[k-1][5:0], step[k].q2};
			end
		end
	end

	assign quo = q_s[bmac_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

[hdl/bmac_obuf.sv]
// two-entry output buffer with skid slot between pipeline and result port
// depends on bmac_pkg
`default_nettype none
module bmac_obuf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire bmac_pkg::bmac_pix_t pix_in,
	input  wire logic                out_stall,
	output bmac_pkg::bmac_pix_t      pix_q,
	output logic                     out_valid,
	output logic                     full
);

	logic                out_valid_q;
	logic                skid_valid_q;
	bmac_pkg::bmac_pix_t skid_q;
	logic                pop;

	assign pop = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				pix_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				pix_q <= pix_in;
			end else begin
				skid_q <= pix_in;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign full      = skid_valid_q;

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot holds a transaction while the main slot is empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("pipeline pushed into a full output buffer");

	a_stalled_push_skids: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && push) |=> skid_valid_q)
		else $error("stalled push did not land in the skid slot");

endmodule
`default_nettype wire
